### src/spisr_pkg.sv
// ----------------------------------------------------------------------------
// SPI slave register responder package
// Shared constants, command codes and the state/result types used by the
// decision logic and the top level.
// ----------------------------------------------------------------------------
package spisr_pkg;

    // Capture buffer for write frames.
    localparam int CAPTURE_DEPTH = 10;
    localparam int CAP_IDX_W     = 4;
    localparam logic [CAP_IDX_W-1:0] CAP_IDX_MAX = {CAP_IDX_W{1'b1}};
    localparam int FRAME_BYTES   = 6;

    // Command and reply bytes.
    localparam logic [7:0] CMD_ID_START  = 8'hA0;
    localparam logic [7:0] CMD_ID_SLAVE  = 8'hA1;
    localparam logic [7:0] CMD_ID_FUNC   = 8'hA2;
    localparam logic [7:0] CMD_ID_RDCNT  = 8'hA3;
    localparam logic [7:0] CMD_ID_WRCNT  = 8'hA4;
    localparam logic [7:0] CMD_ID_END    = 8'hA5;
    localparam logic [7:0] CMD_RD_START  = 8'hB0;
    localparam logic [7:0] CMD_RD_END    = 8'hB1;
    localparam logic [7:0] RSP_RD_ACK    = 8'hC0;
    localparam logic [7:0] CMD_WR_START  = 8'hD0;
    localparam logic [7:0] RSP_LEN_SHORT = 8'h02;
    localparam logic [7:0] RSP_LEN_LONG  = 8'h04;
    localparam logic [7:0] RSP_LEN_BAD   = 8'h01;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_FLAGS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_REG_CNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_REG_CNT  = 2'd3;

    localparam logic [7:0] SLAVE_ID_RST   = 8'd9;
    localparam logic [7:0] FUNC_FLAGS_RST = 8'd1;
    localparam logic [7:0] RD_REG_CNT_RST = 8'd4;
    localparam logic [7:0] WR_REG_CNT_RST = 8'd3;

    typedef struct packed {
        logic [7:0] slave_id;
        logic [7:0] function_flags;
        logic [7:0] read_register_count;
        logic [7:0] write_register_count;
    } cfg_t;

    typedef struct packed {
        logic                              id_active;
        logic                              read_active;
        logic                              write_active;
        logic                              reply_active;
        logic [2:0]                        reply_index;
        logic [2:0]                        reply_length;
        logic [3:0][7:0]                   reply_bytes;
        logic [CAP_IDX_W-1:0]              capture_index;
        logic [CAPTURE_DEPTH-1:0][7:0]     capture_bytes;
    } resp_state_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  rx_byte;
        logic [31:0] response_word;
    } item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_loaded;
        logic        measure_request;
        logic        master_interrupt;
        logic        write_done;
        logic [47:0] write_frame;
    } result_t;

endpackage

### src/spisr_step.sv
// ----------------------------------------------------------------------------
// SPI slave register responder decision logic
// Applies the frame rules to one item in order and produces the next
// responder state and the result for that item.
// ----------------------------------------------------------------------------
module spisr_step import spisr_pkg::*; (
    input  cfg_t        cfg,
    input  resp_state_t cur,
    input  item_t       item,
    output resp_state_t nxt,
    output result_t     res
);

    always_comb begin
        logic [7:0]           b;
        logic [CAP_IDX_W-1:0] idx_m1;
        b      = item.rx_byte;
        idx_m1 = cur.capture_index - CAP_IDX_W'(1);
        nxt    = cur;
        res    = '0;
        res.tx_byte = b;

        if (item.action) begin
            nxt.reply_bytes[0] = item.response_word[31:24];
            nxt.reply_bytes[1] = item.response_word[23:16];
            nxt.reply_bytes[2] = item.response_word[15:8];
            nxt.reply_bytes[3] = item.response_word[7:0];
            nxt.reply_index    = '0;
            nxt.reply_active   = 1'b1;
            res.master_interrupt = 1'b1;
            res.tx_byte        = '0;
        end else begin
            // Identification frame. Later rules see the updated flags.
            if (b == CMD_ID_START && !nxt.write_active) begin
                nxt.id_active = 1'b1;
                res.tx_byte   = CMD_ID_START;
                res.tx_loaded = 1'b1;
            end
            if (nxt.id_active && b != CMD_ID_END) begin
                case (b)
                    CMD_ID_SLAVE: begin
                        res.tx_byte   = cfg.slave_id;
                        res.tx_loaded = 1'b1;
                    end
                    CMD_ID_FUNC: begin
                        res.tx_byte   = cfg.function_flags;
                        res.tx_loaded = 1'b1;
                    end
                    CMD_ID_RDCNT: begin
                        res.tx_byte   = cfg.read_register_count;
                        res.tx_loaded = 1'b1;
                    end
                    CMD_ID_WRCNT: begin
                        res.tx_byte   = cfg.write_register_count;
                        res.tx_loaded = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (nxt.id_active && b == CMD_ID_END) begin
                nxt.id_active = 1'b0;
                res.tx_byte   = CMD_RD_START;
                res.tx_loaded = 1'b1;
            end

            // Read request frame.
            if (b == CMD_RD_START && !nxt.write_active) begin
                nxt.read_active = 1'b1;
                res.tx_byte     = CMD_RD_START;
                res.tx_loaded   = 1'b1;
            end
            if (nxt.read_active && b != CMD_RD_START) begin
                if (b <= 8'd1) begin
                    nxt.reply_length = 3'd2;
                    res.tx_byte      = RSP_LEN_SHORT;
                end else if (b <= 8'd3) begin
                    nxt.reply_length = 3'd4;
                    res.tx_byte      = RSP_LEN_LONG;
                end else begin
                    res.tx_byte      = RSP_LEN_BAD;
                end
                res.tx_loaded = 1'b1;
            end
            if (nxt.read_active && b == CMD_RD_END) begin
                res.measure_request = 1'b1;
                nxt.read_active     = 1'b0;
                nxt.reply_active    = 1'b0;
                res.tx_byte         = RSP_RD_ACK;
                res.tx_loaded       = 1'b1;
            end

            // Stored reply bytes go out one per received byte.
            if (nxt.reply_active && nxt.reply_index < nxt.reply_length) begin
                res.tx_byte     = nxt.reply_bytes[nxt.reply_index[1:0]];
                res.tx_loaded   = 1'b1;
                nxt.reply_index = nxt.reply_index + 3'd1;
            end

            // Write frame capture. A start byte never counts as a capture.
            if (b == CMD_WR_START && !nxt.write_active) begin
                nxt.write_active  = 1'b1;
                nxt.capture_index = '0;
            end
            if (nxt.write_active && b != CMD_WR_START) begin
                for (int k = 0; k < CAPTURE_DEPTH; k++) begin
                    if ({1'b0, nxt.capture_index} == (CAP_IDX_W + 1)'(k)) begin
                        nxt.capture_bytes[k] = b;
                    end
                end
                idx_m1 = nxt.capture_index - CAP_IDX_W'(1);
                if (nxt.capture_index > CAP_IDX_W'(1) &&
                    {{(8 - CAP_IDX_W){1'b0}}, idx_m1} == nxt.capture_bytes[1]) begin
                    nxt.write_active = 1'b0;
                    res.write_done   = 1'b1;
                    for (int k = 0; k < FRAME_BYTES; k++) begin
                        res.write_frame[(FRAME_BYTES - 1 - k) * 8 +: 8] =
                            nxt.capture_bytes[k];
                    end
                end
                if (nxt.capture_index != CAP_IDX_MAX) begin
                    nxt.capture_index = nxt.capture_index + CAP_IDX_W'(1);
                end
            end
        end
    end

endmodule

### src/spi_slave_register_responder_top.sv
// ----------------------------------------------------------------------------
// SPI slave register responder
// Decides the byte loaded for the next SPI exchange from each received byte.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled. An
// accepted item is held in an input register, decided combinationally by the
// rule logic and written to the result register together with the new responder
// state once that register is free. The input register and the result register
// each hold one item, so one more item is taken while a finished result waits
// on m_ready. Configuration registers are read directly by the rule logic and
// should only be written while no item is in flight.
module spi_slave_register_responder_top import spisr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [7:0]           s_rx_byte,
    input  logic [31:0]          s_response_word,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_tx_byte,
    output logic                 m_tx_loaded,
    output logic                 m_measure_request,
    output logic                 m_master_interrupt,
    output logic                 m_write_done,
    output logic [47:0]          m_write_frame
);

    cfg_t        cfg_reg;
    resp_state_t state_reg, state_next;
    item_t       item_reg;
    logic        item_vld_reg;
    result_t     res_reg, res_next;
    logic        res_vld_reg;
    logic        advance;

    // The held item moves to the result register when that slot is free or being emptied.
    assign advance = item_vld_reg && (!res_vld_reg || m_ready);
    assign s_ready = !item_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_id             <= SLAVE_ID_RST;
            cfg_reg.function_flags       <= FUNC_FLAGS_RST;
            cfg_reg.read_register_count  <= RD_REG_CNT_RST;
            cfg_reg.write_register_count <= WR_REG_CNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SLAVE_ID:   cfg_reg.slave_id             <= cfg_wdata;
                CFG_FUNC_FLAGS: cfg_reg.function_flags       <= cfg_wdata;
                CFG_RD_REG_CNT: cfg_reg.read_register_count  <= cfg_wdata;
                CFG_WR_REG_CNT: cfg_reg.write_register_count <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (s_ready) begin
            item_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action        <= s_action;
            item_reg.rx_byte       <= s_rx_byte;
            item_reg.response_word <= s_response_word;
        end
    end

    spisr_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Reply bytes are only read after a response item has written them, so
    // they are left out of the reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.id_active     <= 1'b0;
            state_reg.read_active   <= 1'b0;
            state_reg.write_active  <= 1'b0;
            state_reg.reply_active  <= 1'b0;
            state_reg.reply_index   <= '0;
            state_reg.reply_length  <= '0;
            state_reg.capture_index <= '0;
            state_reg.capture_bytes <= '0;
        end else if (advance) begin
            state_reg.id_active     <= state_next.id_active;
            state_reg.read_active   <= state_next.read_active;
            state_reg.write_active  <= state_next.write_active;
            state_reg.reply_active  <= state_next.reply_active;
            state_reg.reply_index   <= state_next.reply_index;
            state_reg.reply_length  <= state_next.reply_length;
            state_reg.reply_bytes   <= state_next.reply_bytes;
            state_reg.capture_index <= state_next.capture_index;
            state_reg.capture_bytes <= state_next.capture_bytes;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else if (advance) begin
            res_vld_reg <= 1'b1;
        end else if (m_ready) begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = res_vld_reg;
    assign m_tx_byte          = res_reg.tx_byte;
    assign m_tx_loaded        = res_reg.tx_loaded;
    assign m_measure_request  = res_reg.measure_request;
    assign m_master_interrupt = res_reg.master_interrupt;
    assign m_write_done       = res_reg.write_done;
    assign m_write_frame      = res_reg.write_frame;

endmodule

### src/spisr_checker.sv
// ----------------------------------------------------------------------------
// SPI slave register responder port checker
// Watches the top-level ports for result consistency and output stability.
// ----------------------------------------------------------------------------
module spisr_checker import spisr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [7:0]           m_tx_byte,
    input logic                 m_tx_loaded,
    input logic                 m_measure_request,
    input logic                 m_master_interrupt,
    input logic                 m_write_done,
    input logic [47:0]          m_write_frame
);

    // No result may be presented right after reset.
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid in the cycle after reset");

    // A stalled result must hold its contents.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) &&
            $stable(m_write_frame) && $stable(m_tx_loaded))
        else $error("stalled result changed");

    // A response-ready item loads nothing and raises no other pulse.
    a_interrupt_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_master_interrupt |-> !m_tx_loaded && m_tx_byte == 8'h00 &&
            !m_measure_request && !m_write_done)
        else $error("master interrupt with other activity");

    // The end of a read frame always acknowledges with the fixed code.
    a_measure_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_measure_request |-> m_tx_loaded && m_tx_byte == RSP_RD_ACK)
        else $error("measure request without acknowledge byte");

    // The write frame is only shown when a write completes.
    a_frame_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_done |-> m_write_frame == 48'h0)
        else $error("write frame shown without write done");

endmodule

bind spi_slave_register_responder_top spisr_checker u_spisr_checker (.*);

### tb/sv/spisr_tb_pkg.sv
// ----------------------------------------------------------------------------
// SPI slave register responder scoreboard
// Keeps its own copy of the responder state and configuration, works out the
// transmit decision for every accepted transfer and checks each result
// transfer against the oldest decision still waiting.
// ----------------------------------------------------------------------------
package spisr_tb_pkg;
    import spisr_pkg::*;

    class responder_scoreboard;
        logic [7:0]           id_byte;
        logic [7:0]           flags_byte;
        logic [7:0]           rd_count;
        logic [7:0]           wr_count;
        bit                   in_id_frame;
        bit                   in_read_frame;
        bit                   in_write_frame;
        bit                   reply_armed;
        logic [2:0]           reply_pos;
        logic [2:0]           reply_len;
        logic [7:0]           reply_data [4];
        logic [CAP_IDX_W-1:0] cap_pos;
        logic [7:0]           cap_data [CAPTURE_DEPTH];
        result_t              tx_decisions_q [$];
        int                   errors;

        function new();
            id_byte        = SLAVE_ID_RST;
            flags_byte     = FUNC_FLAGS_RST;
            rd_count       = RD_REG_CNT_RST;
            wr_count       = WR_REG_CNT_RST;
            in_id_frame    = 1'b0;
            in_read_frame  = 1'b0;
            in_write_frame = 1'b0;
            reply_armed    = 1'b0;
            reply_pos      = '0;
            reply_len      = '0;
            cap_pos        = '0;
            foreach (reply_data[i]) reply_data[i] = '0;
            foreach (cap_data[i]) cap_data[i] = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                CFG_SLAVE_ID:   id_byte = value;
                CFG_FUNC_FLAGS: flags_byte = value;
                CFG_RD_REG_CNT: rd_count = value;
                CFG_WR_REG_CNT: wr_count = value;
                default: ;
            endcase
        endfunction

        // True when the next captured byte of a write frame is its count byte.
        function bit count_byte_next();
            return in_write_frame && cap_pos == 1;
        endfunction

        function int pending();
            return tx_decisions_q.size();
        endfunction

        function result_t predict_tx_decision(item_t it);
            result_t    r;
            logic [7:0] b;
            b = it.rx_byte;
            r = '0;
            r.tx_byte = b;
            if (it.action) begin
                reply_data[0] = it.response_word[31:24];
                reply_data[1] = it.response_word[23:16];
                reply_data[2] = it.response_word[15:8];
                reply_data[3] = it.response_word[7:0];
                reply_pos = '0;
                reply_armed = 1'b1;
                r.master_interrupt = 1'b1;
                r.tx_byte = '0;
            end else begin
                // Rules are applied in order; a later load overrides an earlier one.
                if (b == CMD_ID_START && !in_write_frame) begin
                    in_id_frame = 1'b1;
                    r.tx_byte = CMD_ID_START;
                    r.tx_loaded = 1'b1;
                end
                if (in_id_frame && b != CMD_ID_END) begin
                    case (b)
                        CMD_ID_SLAVE: begin r.tx_byte = id_byte;    r.tx_loaded = 1'b1; end
                        CMD_ID_FUNC:  begin r.tx_byte = flags_byte; r.tx_loaded = 1'b1; end
                        CMD_ID_RDCNT: begin r.tx_byte = rd_count;   r.tx_loaded = 1'b1; end
                        CMD_ID_WRCNT: begin r.tx_byte = wr_count;   r.tx_loaded = 1'b1; end
                        default: ;
                    endcase
                end
                if (in_id_frame && b == CMD_ID_END) begin
                    in_id_frame = 1'b0;
                    r.tx_byte = CMD_RD_START;
                    r.tx_loaded = 1'b1;
                end
                if (b == CMD_RD_START && !in_write_frame) begin
                    in_read_frame = 1'b1;
                    r.tx_byte = CMD_RD_START;
                    r.tx_loaded = 1'b1;
                end
                if (in_read_frame && b != CMD_RD_START) begin
                    if (b <= 8'd1) begin
                        reply_len = 3'd2;
                        r.tx_byte = RSP_LEN_SHORT;
                    end else if (b <= 8'd3) begin
                        reply_len = 3'd4;
                        r.tx_byte = RSP_LEN_LONG;
                    end else begin
                        r.tx_byte = RSP_LEN_BAD;
                    end
                    r.tx_loaded = 1'b1;
                end
                if (in_read_frame && b == CMD_RD_END) begin
                    r.measure_request = 1'b1;
                    in_read_frame = 1'b0;
                    reply_armed = 1'b0;
                    r.tx_byte = RSP_RD_ACK;
                    r.tx_loaded = 1'b1;
                end
                if (reply_armed && reply_pos < reply_len) begin
                    r.tx_byte = reply_data[reply_pos[1:0]];
                    r.tx_loaded = 1'b1;
                    reply_pos = reply_pos + 3'd1;
                end
                if (b == CMD_WR_START && !in_write_frame) begin
                    in_write_frame = 1'b1;
                    cap_pos = '0;
                end
                if (in_write_frame && b != CMD_WR_START) begin
                    if (cap_pos < CAPTURE_DEPTH) cap_data[cap_pos] = b;
                    if (cap_pos > 1 && ({4'd0, cap_pos} - 8'd1) == cap_data[1]) begin
                        in_write_frame = 1'b0;
                        r.write_done = 1'b1;
                        for (int k = 0; k < FRAME_BYTES; k++) begin
                            r.write_frame = {r.write_frame[39:0], cap_data[k]};
                        end
                    end
                    if (cap_pos != CAP_IDX_MAX) cap_pos = cap_pos + 1'b1;
                end
            end
            return r;
        endfunction

        function void note_item(item_t it);
            tx_decisions_q.push_back(predict_tx_decision(it));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (tx_decisions_q.size() == 0) begin
                $error("result transfer with no decision waiting: tx_byte %0h", got.tx_byte);
                errors++;
                return;
            end
            want = tx_decisions_q.pop_front();
            if (got.tx_byte !== want.tx_byte) begin
                $error("tx_byte expected %0h actual %0h", want.tx_byte, got.tx_byte);
                errors++;
            end
            if (got.tx_loaded !== want.tx_loaded) begin
                $error("tx_loaded expected %0b actual %0b", want.tx_loaded, got.tx_loaded);
                errors++;
            end
            if (got.measure_request !== want.measure_request) begin
                $error("measure_request expected %0b actual %0b",
                       want.measure_request, got.measure_request);
                errors++;
            end
            if (got.master_interrupt !== want.master_interrupt) begin
                $error("master_interrupt expected %0b actual %0b",
                       want.master_interrupt, got.master_interrupt);
                errors++;
            end
            if (got.write_done !== want.write_done) begin
                $error("write_done expected %0b actual %0b", want.write_done, got.write_done);
                errors++;
            end
            if (got.write_frame !== want.write_frame) begin
                $error("write_frame expected %0h actual %0h", want.write_frame, got.write_frame);
                errors++;
            end
        endfunction
    endclass

endpackage

### tb/sv/spi_slave_register_responder_top_tb.sv
// ----------------------------------------------------------------------------
// SPI slave register responder testbench
// Drives identification, read, response and write frames plus noise through
// the input channel under several register settings, with random gaps and
// back-pressure, and checks every result transfer against the scoreboard.
// ----------------------------------------------------------------------------
module spi_slave_register_responder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spisr_pkg::*;
    import spisr_tb_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int GAP_PCT        = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = 1'b0;
    logic [7:0]           s_rx_byte = '0;
    logic [31:0]          s_response_word = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_tx_byte;
    logic                 m_tx_loaded;
    logic                 m_measure_request;
    logic                 m_master_interrupt;
    logic                 m_write_done;
    logic [47:0]          m_write_frame;

    responder_scoreboard sb;
    int                  items_sent = 0;
    int                  quiet_cycles = 0;
    bit                  gaps_on = 1'b1;
    bit                  hang_ok = 1'b0;

    spi_slave_register_responder_top u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_rx_byte          (s_rx_byte),
        .s_response_word    (s_response_word),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_tx_byte          (m_tx_byte),
        .m_tx_loaded        (m_tx_loaded),
        .m_measure_request  (m_measure_request),
        .m_master_interrupt (m_master_interrupt),
        .m_write_done       (m_write_done),
        .m_write_frame      (m_write_frame)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_tx_byte, m_tx_loaded, m_measure_request,
                             m_master_interrupt, m_write_done, m_write_frame});
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Command bytes come up often so that random bytes hit the frame rules.
    function automatic logic [7:0] any_byte();
        logic [7:0] codes [13] = '{CMD_ID_START, CMD_ID_SLAVE, CMD_ID_FUNC, CMD_ID_RDCNT,
                                   CMD_ID_WRCNT, CMD_ID_END, CMD_RD_START, CMD_RD_END,
                                   CMD_WR_START, 8'h00, 8'h01, 8'h02, 8'h03};
        if ($urandom_range(3) == 0) return codes[$urandom_range(12)];
        return 8'($urandom());
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_item(input logic act, input logic [7:0] rx, input logic [31:0] word);
        item_t it;
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        // A count byte of zero or above fourteen locks the write frame for good,
        // so it is only allowed in the closing part of the run.
        if (!act && !hang_ok && sb.count_byte_next() && rx != CMD_WR_START &&
            (rx == 8'd0 || rx >= 8'd15)) begin
            rx = 8'($urandom_range(1, 14));
        end
        it = {act, rx, word};
        s_valid <= 1'b1;
        s_action <= act;
        s_rx_byte <= rx;
        s_response_word <= word;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic configure(input logic [7:0] id_v, input logic [7:0] flags_v,
                             input logic [7:0] rd_v, input logic [7:0] wr_v);
        settle();
        write_reg(CFG_SLAVE_ID, id_v);
        write_reg(CFG_FUNC_FLAGS, flags_v);
        write_reg(CFG_RD_REG_CNT, rd_v);
        write_reg(CFG_WR_REG_CNT, wr_v);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int         stop_at;
        int         len;
        logic [7:0] cnt;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1: begin
                    send_item(1'b0, CMD_ID_START, $urandom());
                    len = $urandom_range(1, 6);
                    repeat (len) begin
                        send_item(1'b0, ($urandom_range(3) != 0) ?
                                  8'($urandom_range(CMD_ID_SLAVE, CMD_ID_WRCNT)) : any_byte(),
                                  $urandom());
                    end
                    if ($urandom_range(4) != 0) send_item(1'b0, CMD_ID_END, $urandom());
                end
                2, 3: begin
                    send_item(1'b0, CMD_RD_START, $urandom());
                    send_item(1'b0, ($urandom_range(4) != 0) ? 8'($urandom_range(3)) : any_byte(),
                              $urandom());
                    if ($urandom_range(4) != 0) send_item(1'b0, CMD_RD_END, $urandom());
                    if ($urandom_range(9) < 7) begin
                        send_item(1'b1, 8'($urandom()), $urandom());
                        repeat ($urandom_range(1, 5)) send_item(1'b0, any_byte(), $urandom());
                    end
                end
                4: begin
                    send_item(1'b1, 8'($urandom()), $urandom());
                    repeat ($urandom_range(0, 5)) send_item(1'b0, any_byte(), $urandom());
                end
                5, 6: begin
                    cnt = 8'($urandom_range(1, 14));
                    len = cnt + 2;
                    // Some frames are cut short and run into whatever follows.
                    if ($urandom_range(4) == 0) len = $urandom_range(1, len);
                    send_item(1'b0, CMD_WR_START, $urandom());
                    for (int k = 0; k < len; k++) begin
                        send_item(1'b0, (k == 1) ? cnt : any_byte(), $urandom());
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(9) == 0) send_item(1'b1, 8'($urandom()), $urandom());
                        else send_item(1'b0, any_byte(), $urandom());
                    end
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Identification frame with the register reset values.
        send_item(1'b0, CMD_ID_START, $urandom());
        send_item(1'b0, CMD_ID_SLAVE, $urandom());
        send_item(1'b0, CMD_ID_FUNC, $urandom());
        send_item(1'b0, CMD_ID_RDCNT, $urandom());
        send_item(1'b0, CMD_ID_WRCNT, $urandom());
        send_item(1'b0, CMD_ID_END, $urandom());
        // Short read, then the response data and its readout plus one echo.
        send_item(1'b0, CMD_RD_START, $urandom());
        send_item(1'b0, 8'h00, $urandom());
        send_item(1'b0, CMD_RD_END, $urandom());
        send_item(1'b1, 8'hFF, 32'hFFFF_FFFF);
        send_item(1'b0, 8'h00, 32'h0000_0000);
        send_item(1'b0, 8'hFF, $urandom());
        send_item(1'b0, 8'h7E, $urandom());
        // Read request for an unknown register.
        send_item(1'b0, CMD_RD_START, $urandom());
        send_item(1'b0, 8'hFF, $urandom());
        send_item(1'b0, CMD_RD_END, $urandom());
        // Shortest write frame; the rest of the forwarded bytes are stale.
        send_item(1'b0, CMD_WR_START, $urandom());
        send_item(1'b0, 8'h5A, $urandom());
        send_item(1'b0, 8'h01, $urandom());
        send_item(1'b0, 8'h3C, $urandom());
        // Response data that nobody asked for, then one readout.
        send_item(1'b1, 8'h00, 32'h0000_0000);
        send_item(1'b0, 8'h55, $urandom());

        run_random(200);
        configure(8'h00, 8'h00, 8'h00, 8'h00);
        run_random(220);
        configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(220);
        configure(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        gaps_on = 1'b0;
        run_random(220);
        gaps_on = 1'b1;
        configure(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        run_random(220);
        configure(SLAVE_ID_RST, FUNC_FLAGS_RST, RD_REG_CNT_RST, WR_REG_CNT_RST);
        run_random(200);

        // Close any open write frame, then lock one with a count it can never reach.
        while (sb.in_write_frame) send_item(1'b0, 8'($urandom()), $urandom());
        hang_ok = 1'b1;
        send_item(1'b0, CMD_WR_START, $urandom());
        send_item(1'b0, 8'($urandom()), $urandom());
        send_item(1'b0, ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(15, 255)),
                  $urandom());
        run_random(40);

        settle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
